// ----- design/plcc_pkg.sv -----
// shared types, constants and keyword lookup for the pawn lexer classifier
package plcc_pkg;

  localparam int KwMax    = 7;
  localparam int KwCount  = 19;
  localparam int PosW     = 10;
  localparam int QDepth   = 4;
  localparam int QPtrW    = 2;

  // lexical classes
  localparam logic [3:0] CLS_DEFAULT = 4'd0;
  localparam logic [3:0] CLS_BLOCK   = 4'd1;
  localparam logic [3:0] CLS_LINE    = 4'd2;
  localparam logic [3:0] CLS_IDENT   = 4'd3;
  localparam logic [3:0] CLS_KEYWORD = 4'd4;
  localparam logic [3:0] CLS_NUMBER  = 4'd5;
  localparam logic [3:0] CLS_CHAR    = 4'd6;
  localparam logic [3:0] CLS_STRING  = 4'd7;
  localparam logic [3:0] CLS_PREPROC = 4'd8;

  typedef enum logic [3:0] {
    MODE_DEFAULT, MODE_SLASH, MODE_BLOCK, MODE_BLOCK_STAR, MODE_LINE,
    MODE_IDENT, MODE_NUMBER, MODE_CHAR, MODE_STRING, MODE_PREPROC
  } mode_t;

  typedef struct packed {
    logic [PosW-1:0] pos;
    logic [2:0]      len;
    logic [3:0]      cls;
  } result_t;

  // all results caused by one input transfer
  typedef struct packed {
    logic [1:0] count;
    result_t    r2;
    result_t    r1;
    result_t    r0;
  } bundle_t;

  localparam logic [63:0] INCLUDE_WORD = "#include";

  localparam logic [55:0] KW_TEXT [KwCount] = '{
    56'("const"), 56'("defined"), 56'("do"), 56'("else"), 56'("enum"),
    56'("false"), 56'("for"), 56'("forward"), 56'("if"), 56'("native"),
    56'("new"), 56'("public"), 56'("return"), 56'("sizeof"), 56'("static"),
    56'("stock"), 56'("tagof"), 56'("true"), 56'("while")
  };
  localparam logic [2:0] KW_LEN [KwCount] = '{
    3'd5, 3'd7, 3'd2, 3'd4, 3'd4, 3'd5, 3'd3, 3'd7, 3'd2, 3'd6,
    3'd3, 3'd6, 3'd6, 3'd6, 3'd6, 3'd5, 3'd5, 3'd4, 3'd5
  };

  // byte of "#include" at a given match position
  function automatic logic [7:0] include_char(input logic [2:0] idx);
    logic [2:0] rev;
    rev = 3'd7 - idx;
    return INCLUDE_WORD[{rev, 3'b000} +: 8];
  endfunction

  // identifier buffer against the keyword list
  function automatic logic kw_match(input logic [7:0] buf_in [KwMax],
                                    input logic [3:0] len);
    logic [55:0] word;
    logic        hit;
    word = '0;
    hit  = 1'b0;
    for (int i = 0; i < KwMax; i++) begin
      if (4'(i) < len) begin
        word = {word[47:0], buf_in[i]};
      end
    end
    for (int k = 0; k < KwCount; k++) begin
      if ({1'b0, KW_LEN[k]} == len && KW_TEXT[k] == word) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

// ----- design/pawn_lexer_char_classifier.sv -----
// top level of the pawn lexer character classifier
// a byte's results are formed combinationally and registered in the queue before they are offered
// throughput: one byte per cycle while the queue is not full; a byte with k results takes k output transfers
// a four-bundle queue lets input run ahead of a stalled output
// reset: synchronous; lexer returns to default mode at line position zero, queue empties
module pawn_lexer_char_classifier
  import plcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // char_code
  input  logic        s_tuser,   // char_present
  input  logic        s_tlast,   // last_in_line
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // char_position, span_length, color_class, zero fill
  output logic        m_tlast    // last_result
);

  logic    take, push, full, pop, head_valid;
  bundle_t bundle, head;

  assign s_tready = !full;
  assign take     = s_tvalid && s_tready;

  plcc_front u_front (
    .clk, .rst, .take,
    .char_code(s_tdata), .char_present(s_tuser), .last_in_line(s_tlast),
    .push, .bundle
  );

  plcc_queue u_queue (
    .clk, .rst, .push, .push_data(bundle), .full,
    .pop, .head_valid, .head
  );

  plcc_back u_back (
    .clk, .rst, .head_valid, .head, .pop,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast
  );

  // every result covers at least one character
  a_span_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[12:10] != 3'd0)
    else $error("zero span length");

  // classes stay within the defined set
  a_class_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[16:13] <= CLS_PREPROC)
    else $error("class out of range");

  // a queued bundle is never empty
  a_bundle_count: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> head.count != 2'd0)
    else $error("empty bundle queued");

endmodule

// ----- design/plcc_front.sv -----
// front end: lexer state and per-byte classification into result bundles
module plcc_front
  import plcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] char_code,
  input  logic       char_present,
  input  logic       last_in_line,
  output logic       push,
  output bundle_t    bundle
);

  mode_t           mode, mode_next;
  logic [7:0]      ibuf [KwMax];
  logic [7:0]      ibuf_next [KwMax];
  logic [3:0]      ilen, ilen_next;
  logic [PosW-1:0] istart, istart_next;
  logic [PosW-1:0] lpos, lpos_next;
  logic [3:0]      incl, incl_next;
  logic            rstr, rstr_next;
  result_t         res [3];
  logic [1:0]      cnt;

  // character sets of the input byte
  logic c_letter, c_digit, c_first, c_identch, c_numch, c_space;
  assign c_letter  = (char_code >= "a" && char_code <= "z") ||
                     (char_code >= "A" && char_code <= "Z");
  assign c_digit   = char_code >= "0" && char_code <= "9";
  assign c_first   = c_letter || char_code == "_" || char_code == "@";
  assign c_identch = c_first || c_digit;
  assign c_numch   = c_digit || (char_code >= "a" && char_code <= "f") ||
                     (char_code >= "A" && char_code <= "F") ||
                     char_code == "x" || char_code == ".";
  assign c_space   = (char_code >= 8'd9 && char_code <= 8'd13) || char_code == " ";

  // classification of one transfer, in the order results are produced
  always_comb begin
    logic run_default;
    logic run_close;
    run_default = 1'b0;
    run_close   = 1'b0;
    mode_next   = mode;
    ibuf_next   = ibuf;
    ilen_next   = ilen;
    istart_next = istart;
    lpos_next   = lpos;
    incl_next   = incl;
    rstr_next   = rstr;
    cnt         = 2'd0;
    for (int i = 0; i < 3; i++) res[i] = '0;

    if (char_present) begin
      // track "#include" on this line
      if (incl < 4'd8) begin
        if (char_code == include_char(incl[2:0])) incl_next = incl + 4'd1;
        else if (char_code == "#") incl_next = 4'd1;
        else incl_next = 4'd0;
      end
      if (rstr) begin
        res[cnt] = '{lpos, 3'd1, CLS_STRING}; cnt = cnt + 2'd1;
      end else begin
        case (mode)
          MODE_SLASH: begin
            if (char_code == "/") begin
              res[cnt] = '{istart, 3'd2, CLS_LINE}; cnt = cnt + 2'd1;
              mode_next = MODE_LINE;
            end else if (char_code == "*") begin
              res[cnt] = '{istart, 3'd2, CLS_BLOCK}; cnt = cnt + 2'd1;
              mode_next = MODE_BLOCK;
            end else begin
              res[cnt] = '{istart, 3'd1, CLS_DEFAULT}; cnt = cnt + 2'd1;
              run_default = 1'b1;
            end
          end
          MODE_BLOCK: begin
            res[cnt] = '{lpos, 3'd1, CLS_BLOCK}; cnt = cnt + 2'd1;
            if (char_code == "*") mode_next = MODE_BLOCK_STAR;
          end
          MODE_BLOCK_STAR: begin
            res[cnt] = '{lpos, 3'd1, CLS_BLOCK}; cnt = cnt + 2'd1;
            if (char_code == "/") mode_next = MODE_DEFAULT;
            else if (char_code != "*") mode_next = MODE_BLOCK;
          end
          MODE_LINE: begin
            res[cnt] = '{lpos, 3'd1, CLS_LINE}; cnt = cnt + 2'd1;
          end
          MODE_IDENT: begin
            if (c_identch) begin
              if (ilen < 4'd7) ibuf_next[ilen[2:0]] = char_code;
              if (ilen <= 4'd7) ilen_next = ilen + 4'd1;
              res[cnt] = '{lpos, 3'd1, CLS_IDENT}; cnt = cnt + 2'd1;
            end else begin
              run_close   = 1'b1;
              run_default = 1'b1;
            end
          end
          MODE_NUMBER: begin
            if (c_numch) begin
              res[cnt] = '{lpos, 3'd1, CLS_NUMBER}; cnt = cnt + 2'd1;
            end else begin
              run_default = 1'b1;
            end
          end
          MODE_CHAR: begin
            res[cnt] = '{lpos, 3'd1, CLS_CHAR}; cnt = cnt + 2'd1;
            if (char_code == "'") mode_next = MODE_DEFAULT;
          end
          MODE_STRING: begin
            res[cnt] = '{lpos, 3'd1, CLS_STRING}; cnt = cnt + 2'd1;
            if (char_code == "\"") mode_next = MODE_DEFAULT;
          end
          MODE_PREPROC: begin
            if (c_space) begin
              res[cnt] = '{lpos, 3'd1, CLS_DEFAULT}; cnt = cnt + 2'd1;
              mode_next = MODE_DEFAULT;
            end else begin
              res[cnt] = '{lpos, 3'd1, CLS_PREPROC}; cnt = cnt + 2'd1;
            end
          end
          default: begin
            run_default = 1'b1;
          end
        endcase
        // identifier ended by this byte
        if (run_close) begin
          if (ilen <= 4'd7 && kw_match(ibuf, ilen)) begin
            res[cnt] = '{istart, ilen[2:0], CLS_KEYWORD}; cnt = cnt + 2'd1;
          end
          ilen_next = 4'd0;
        end
        // byte seen in default mode
        if (run_default) begin
          mode_next = MODE_DEFAULT;
          if (char_code == "'") begin
            mode_next = MODE_CHAR;
            res[cnt] = '{lpos, 3'd1, CLS_CHAR}; cnt = cnt + 2'd1;
          end else if (c_first) begin
            mode_next    = MODE_IDENT;
            istart_next  = lpos;
            ibuf_next[0] = char_code;
            ilen_next    = 4'd1;
            res[cnt] = '{lpos, 3'd1, CLS_IDENT}; cnt = cnt + 2'd1;
          end else if (c_digit) begin
            mode_next = MODE_NUMBER;
            res[cnt] = '{lpos, 3'd1, CLS_NUMBER}; cnt = cnt + 2'd1;
          end else if (char_code == "/") begin
            mode_next   = MODE_SLASH;
            istart_next = lpos;
          end else if (char_code == "\"") begin
            mode_next = MODE_STRING;
            res[cnt] = '{lpos, 3'd1, CLS_STRING}; cnt = cnt + 2'd1;
          end else if (char_code == "#") begin
            mode_next = MODE_PREPROC;
            res[cnt] = '{lpos, 3'd1, CLS_PREPROC}; cnt = cnt + 2'd1;
          end else if (char_code == "<" && incl_next >= 4'd8) begin
            rstr_next = 1'b1;
            res[cnt] = '{lpos, 3'd1, CLS_STRING}; cnt = cnt + 2'd1;
          end else begin
            res[cnt] = '{lpos, 3'd1, CLS_DEFAULT}; cnt = cnt + 2'd1;
          end
        end
      end
      lpos_next = lpos + 1'b1;
    end

    // end of line, or empty line marker
    if (!char_present || last_in_line) begin
      if (mode_next == MODE_IDENT) begin
        if (ilen_next <= 4'd7 && kw_match(ibuf_next, ilen_next)) begin
          res[cnt] = '{istart_next, ilen_next[2:0], CLS_KEYWORD}; cnt = cnt + 2'd1;
        end
      end else if (mode_next == MODE_SLASH) begin
        res[cnt] = '{istart_next, 3'd1, CLS_DEFAULT}; cnt = cnt + 2'd1;
      end
      if (mode_next != MODE_BLOCK && mode_next != MODE_BLOCK_STAR) begin
        mode_next = MODE_DEFAULT;
      end
      lpos_next = '0;
      incl_next = 4'd0;
      rstr_next = 1'b0;
      ilen_next = 4'd0;
    end
  end

  assign push   = take && cnt != 2'd0;
  assign bundle = '{cnt, res[2], res[1], res[0]};

  // lexer state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_DEFAULT;
      ilen   <= 4'd0;
      istart <= '0;
      lpos   <= '0;
      incl   <= 4'd0;
      rstr   <= 1'b0;
    end else if (take) begin
      mode   <= mode_next;
      ilen   <= ilen_next;
      istart <= istart_next;
      lpos   <= lpos_next;
      incl   <= incl_next;
      rstr   <= rstr_next;
    end
  end

  // identifier bytes, read only below the held length
  always_ff @(posedge clk) begin
    if (take) ibuf <= ibuf_next;
  end

endmodule

// ----- design/plcc_queue.sv -----
// short queue of result bundles between front and back ends
module plcc_queue
  import plcc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_data,
  output logic    full,
  input  logic    pop,
  output logic    head_valid,
  output bundle_t head
);

  bundle_t           mem [QDepth];
  logic [QPtrW-1:0]  wptr, rptr;
  logic [QPtrW:0]    fill;

  assign full       = fill == (QPtrW+1)'(QDepth);
  assign head_valid = fill != '0;
  assign head       = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_data;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      fill <= fill + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
    end
  end

endmodule

// ----- design/plcc_back.sv -----
// back end: sends the results of each bundle one transfer at a time
module plcc_back
  import plcc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    head_valid,
  input  bundle_t head,
  output logic    pop,
  output logic    m_tvalid,
  input  logic    m_tready,
  output logic [23:0] m_tdata,
  output logic    m_tlast
);

  logic [1:0] idx;
  result_t    cur;
  logic       at_end;

  always_comb begin
    case (idx)
      2'd0:    cur = head.r0;
      2'd1:    cur = head.r1;
      default: cur = head.r2;
    endcase
  end

  assign at_end   = idx == head.count - 2'd1;
  assign m_tvalid = head_valid;
  assign m_tdata  = {7'd0, cur.cls, cur.len, cur.pos};
  assign m_tlast  = at_end;
  assign pop      = head_valid && m_tready && at_end;

  // position within the current bundle
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (head_valid && m_tready) begin
      idx <= at_end ? 2'd0 : idx + 2'd1;
    end
  end

endmodule
